### rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types, widths and helpers for the round-robin schedule block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int TIME_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_PROCS);
    localparam int CNT_W      = $clog2(MAX_PROCS + 1);
    localparam int CLK_W      = TIME_BITS + IDX_W;
    localparam int QUANT_W    = 16;
    localparam int BURST_W    = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_W      = 20;
    localparam int SAT_W      = (CLK_W > OUT_W) ? CLK_W : OUT_W;
    localparam int CMP_W      = (TIME_BITS > QUANT_W) ? TIME_BITS : QUANT_W;
    localparam int S_TDATA_W  = ((BURST_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = OUT_IDX_W + 2 * OUT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [SAT_W-1:0] OUT_MAX = SAT_W'((64'd1 << OUT_W) - 64'd1);

    // one queued input beat: a load, and whether it starts the schedule
    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] burst;
    } load_item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] proc_idx;
        logic [OUT_W-1:0]     comp_time;
        logic [OUT_W-1:0]     wait_time;
        logic                 last;
    } result_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic [CLK_W-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > OUT_MAX) begin
            return OUT_MAX[OUT_W-1:0];
        end
        return w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/rrs_queue.sv
// ----------------------------------------------------------------------------
// rrs_queue
// Front queue: takes input beats, tags loads and schedule starts, and
// buffers them for the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rrs_pkg::BURST_W-1:0]    in_burst,
    input  wire logic                           in_last,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output rrs_pkg::load_item_t                 out_item
);

    rrs_pkg::load_item_t               mem_reg [rrs_pkg::QDEPTH];
    logic [rrs_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [rrs_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [rrs_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                              push, pop;
    rrs_pkg::load_item_t               item;

    assign in_ready  = (cnt_reg != rrs_pkg::QCNT_W'(rrs_pkg::QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        item.start = in_last;
        item.burst = in_burst[rrs_pkg::TIME_BITS-1:0];
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rrs_pkg::QPTR_W'(rrs_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == rrs_pkg::QPTR_W'(rrs_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

### rtl/rrs_back.sv
// ----------------------------------------------------------------------------
// rrs_back
// Scheduler: stores loads, then walks the ready ring one turn at a time
// and registers one result per completed process.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [rrs_pkg::QUANT_W-1:0]    quantum,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire rrs_pkg::load_item_t            in_item,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output rrs_pkg::result_t                    res
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_FETCH = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [rrs_pkg::TIME_BITS-1:0]   burst_mem [rrs_pkg::MAX_PROCS];
    logic [rrs_pkg::TIME_BITS-1:0]   rem_mem   [rrs_pkg::MAX_PROCS];
    logic [rrs_pkg::IDX_W-1:0]       ring_mem  [rrs_pkg::MAX_PROCS];
    logic [rrs_pkg::IDX_W-1:0]       head_reg, head_next;
    logic [rrs_pkg::IDX_W-1:0]       tail_reg, tail_next;
    logic [rrs_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [rrs_pkg::CNT_W-1:0]       loaded_reg, loaded_next;
    logic [rrs_pkg::CLK_W-1:0]       clock_reg, clock_next;
    logic [rrs_pkg::IDX_W-1:0]       proc_reg, proc_next;
    logic                            res_valid_reg, res_valid_next;
    rrs_pkg::result_t                res_reg;

    logic                            can_store, do_load, do_init, out_free;
    logic                            done, do_emit, do_requeue;
    logic [rrs_pkg::CNT_W-1:0]       loaded_inc;
    logic [rrs_pkg::TIME_BITS-1:0]   rem, run;
    logic [rrs_pkg::CLK_W-1:0]       comp;
    logic [rrs_pkg::CLK_W-1:0]       wait_calc;

    assign in_ready   = (state_reg == ST_LOAD);
    assign can_store  = (loaded_reg < rrs_pkg::CNT_W'(rrs_pkg::MAX_PROCS));
    assign do_load    = in_valid && in_ready && can_store;
    assign do_init    = in_valid && in_ready && in_item.start;
    assign loaded_inc = loaded_reg + (can_store ? 1'b1 : 1'b0);
    assign out_free   = !res_valid_reg || res_ready;

    assign rem       = rem_mem[proc_reg];
    assign done      = (rrs_pkg::CMP_W'(rem) <= rrs_pkg::CMP_W'(quantum));
    assign run       = done ? rem : quantum[rrs_pkg::TIME_BITS-1:0];
    assign comp      = clock_reg + rrs_pkg::CLK_W'(run);
    assign wait_calc = comp - rrs_pkg::CLK_W'(burst_mem[proc_reg]);

    assign do_emit    = (state_reg == ST_RUN) && done && out_free;
    assign do_requeue = (state_reg == ST_RUN) && !done;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        loaded_next    = loaded_reg;
        clock_next     = clock_reg;
        proc_next      = proc_reg;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_valid) begin
                    loaded_next = loaded_inc;
                    if (in_item.start) begin
                        head_next  = '0;
                        tail_next  = loaded_inc[rrs_pkg::IDX_W-1:0];
                        count_next = loaded_inc;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                proc_next  = ring_mem[head_reg];
                head_next  = head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (!done) begin
                    clock_next = comp;
                    tail_next  = tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_FETCH;
                end else if (out_free) begin
                    res_valid_next = 1'b1;
                    if (count_reg == '0) begin
                        clock_next  = '0;
                        loaded_next = '0;
                        state_next  = ST_LOAD;
                    end else begin
                        clock_next = comp;
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            loaded_reg    <= '0;
            clock_reg     <= '0;
            proc_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            loaded_reg    <= loaded_next;
            clock_reg     <= clock_next;
            proc_reg      <= proc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            burst_mem[loaded_reg[rrs_pkg::IDX_W-1:0]] <= in_item.burst;
        end
        if (do_load) begin
            rem_mem[loaded_reg[rrs_pkg::IDX_W-1:0]] <= in_item.burst;
        end else if (do_requeue) begin
            rem_mem[proc_reg] <= rem - run;
        end
        if (do_init) begin
            for (int i = 0; i < rrs_pkg::MAX_PROCS; i++) begin
                ring_mem[i] <= rrs_pkg::IDX_W'(i);
            end
        end else if (do_requeue) begin
            ring_mem[tail_reg] <= proc_reg;
        end
        if (do_emit) begin
            res_reg.proc_idx  <= rrs_pkg::OUT_IDX_W'(proc_reg);
            res_reg.comp_time <= rrs_pkg::sat_out(comp);
            res_reg.wait_time <= rrs_pkg::sat_out(wait_calc);
            res_reg.last      <= (count_reg == '0);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rrs_pkg::CNT_W'(rrs_pkg::MAX_PROCS))
        else $error("ready ring count beyond capacity");

    a_fetch_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (count_reg != '0))
        else $error("fetch from empty ready ring");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_emit && count_reg == '0) |=> (state_reg == ST_LOAD && loaded_reg == '0
                                          && res_valid_reg && res_reg.last))
        else $error("final completion did not close the set");

    a_wait_le_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> (res_reg.wait_time <= res_reg.comp_time))
        else $error("waiting time exceeds completion time");

endmodule

`default_nettype wire

### rtl/round_robin_schedule_sim.sv
// ----------------------------------------------------------------------------
// round_robin_schedule_sim
// Round-robin scheduler over up to 16 loaded burst times with a
// configurable quantum; one result beat per completed process.
// ----------------------------------------------------------------------------
// Load beats: accepted one per cycle into a 2-deep queue while it has room,
//   then stored from the queue while the scheduler is loading.
// Schedule: each turn is a ring fetch, then a run; turns per process are
//   ceil(burst / quantum), at least one.
// The scheduler takes no new beat until the last result is registered.
// Reset clears control state and sets the quantum to 2; stores are not cleared.
`default_nettype none

module round_robin_schedule_sim (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rrs_pkg::QUANT_W-1:0]     cfg_wr_data,   // quantum
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rrs_pkg::S_TDATA_W-1:0]   s_tdata,       // burst length
    input  wire logic                            s_tlast,       // closes the set
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // proc index, finish time, wait, zero pad
    output logic [rrs_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast        // final completion
);

    logic [rrs_pkg::QUANT_W-1:0] quantum_reg;
    logic [rrs_pkg::QUANT_W-1:0] quantum_eff;
    logic                        q_valid, q_ready;
    rrs_pkg::load_item_t         q_item;
    rrs_pkg::result_t            res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= rrs_pkg::QUANT_W'(2);
        end else if (cfg_wr_en) begin
            quantum_reg <= cfg_wr_data;
        end
    end

    assign quantum_eff = (quantum_reg == '0) ? rrs_pkg::QUANT_W'(1) : quantum_reg;

    rrs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_burst  (s_tdata[rrs_pkg::BURST_W-1:0]),
        .in_last   (s_tlast),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    rrs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quantum   (quantum_eff),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{(rrs_pkg::M_TDATA_W - rrs_pkg::M_FIELDS_W){1'b0}},
                      res.wait_time, res.comp_time, res.proc_idx};
    assign m_tlast = res.last;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin schedule block. Burst-time beats
// are streamed in sets closed by tlast; a local scheduler predicts every
// completion beat (index, completion time, waiting time, final flag), and
// the monitor checks each output beat in order. The quantum is rewritten
// between idle phases; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 160;

    typedef struct {
        logic [rrs_pkg::OUT_IDX_W-1:0] idx;
        logic [rrs_pkg::OUT_W-1:0]     done_at;
        logic [rrs_pkg::OUT_W-1:0]     waited;
        logic                          final_one;
    } completion_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [rrs_pkg::QUANT_W-1:0]    cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [rrs_pkg::S_TDATA_W-1:0]  s_tdata     = '0;    // burst length
    logic                           s_tlast     = 1'b0;  // closes the set
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    // proc index, finish time, wait, zero pad
    logic [rrs_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;             // final completion

    round_robin_schedule_sim DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // scheduler shadow state
    logic [rrs_pkg::TIME_BITS-1:0] burst_of [rrs_pkg::MAX_PROCS];
    logic [rrs_pkg::TIME_BITS-1:0] left_of  [rrs_pkg::MAX_PROCS];
    int unsigned                   loaded   = 0;
    logic [rrs_pkg::QUANT_W-1:0]   quantum_now = 16'd2;

    completion_t          completions_due [$];
    rrs_pkg::load_item_t  burst_queue [$];
    int                   errors = 0;
    int                   holds_asked = 0;
    int                   holds_taken = 0;

    function automatic logic [rrs_pkg::OUT_W-1:0] clamp_time(input longint unsigned v);
        return ((v >> rrs_pkg::OUT_W) != 0) ? '1 : rrs_pkg::OUT_W'(v);
    endfunction

    function automatic void load_process(input logic [rrs_pkg::TIME_BITS-1:0] b,
                                         input logic fin);
        int unsigned                   ring [$];
        int unsigned                   p;
        longint unsigned               now;
        logic [rrs_pkg::TIME_BITS-1:0] run;
        logic [rrs_pkg::QUANT_W-1:0]   q;
        completion_t                   c;
        if (loaded < rrs_pkg::MAX_PROCS) begin
            burst_of[loaded] = b;
            left_of[loaded]  = b;
            loaded++;
        end
        if (!fin) begin
            return;
        end
        q   = (quantum_now == 0) ? rrs_pkg::QUANT_W'(1) : quantum_now;
        now = 0;
        for (int i = 0; i < loaded; i++) begin
            ring.push_back(i);
        end
        while (ring.size() > 0) begin
            p   = ring.pop_front();
            run = (q < left_of[p]) ? rrs_pkg::TIME_BITS'(q) : left_of[p];
            now += run;
            left_of[p] -= run;
            if (left_of[p] == 0) begin
                c.idx       = rrs_pkg::OUT_IDX_W'(p);
                c.done_at   = clamp_time(now);
                c.waited    = clamp_time(now - burst_of[p]);
                c.final_one = (ring.size() == 0);
                completions_due.push_back(c);
            end else begin
                ring.push_back(p);
            end
        end
        loaded = 0;
    endfunction

    // driver: bursts of beats with random gaps
    int                  run_left = 0;
    int                  gap_left = 0;
    rrs_pkg::load_item_t next_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                load_process(s_tdata[rrs_pkg::BURST_W-1:0], s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (burst_queue.size() > 0) begin
                    next_beat = burst_queue.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= rrs_pkg::S_TDATA_W'(next_beat.burst);
                    s_tlast   <= next_beat.start;
                    if (run_left > 1) begin
                        run_left--;
                    end else begin
                        run_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall modes plus an occasional long hold
    int rx_cycle  = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left == 0 && holds_taken != holds_asked && m_tvalid) begin
                hold_left = LONG_HOLD;
                holds_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 3)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // monitor
    completion_t due;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (completions_due.size() == 0) begin
                $error("result beat with none expected: tdata=%h tlast=%b", m_tdata, m_tlast);
                errors++;
            end else begin
                due = completions_due.pop_front();
                if (m_tdata[rrs_pkg::OUT_IDX_W-1:0] !== due.idx) begin
                    $error("process_index: expected %0d, got %0d",
                           due.idx, m_tdata[rrs_pkg::OUT_IDX_W-1:0]);
                    errors++;
                end
                if (m_tdata[rrs_pkg::OUT_IDX_W +: rrs_pkg::OUT_W] !== due.done_at) begin
                    $error("completion time: expected %0d, got %0d",
                           due.done_at, m_tdata[rrs_pkg::OUT_IDX_W +: rrs_pkg::OUT_W]);
                    errors++;
                end
                if (m_tdata[rrs_pkg::OUT_IDX_W+rrs_pkg::OUT_W +: rrs_pkg::OUT_W]
                        !== due.waited) begin
                    $error("waiting time: expected %0d, got %0d", due.waited,
                           m_tdata[rrs_pkg::OUT_IDX_W+rrs_pkg::OUT_W +: rrs_pkg::OUT_W]);
                    errors++;
                end
                if (m_tlast !== due.final_one) begin
                    $error("last_result: expected %b, got %b", due.final_one, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_beat(input logic [rrs_pkg::BURST_W-1:0] b, input logic fin);
        rrs_pkg::load_item_t it;
        it.burst = b;
        it.start = fin;
        burst_queue.push_back(it);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (burst_queue.size() != 0 || s_tvalid || completions_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic set_quantum(input logic [rrs_pkg::QUANT_W-1:0] q);
        wait_idle();
        repeat (20) @(negedge aclk);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= q;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        quantum_now = q;
        @(negedge aclk);
    endtask

    task automatic add_random_set(input logic [rrs_pkg::QUANT_W-1:0] q, input int n,
                                  output int added);
        int unsigned cap;
        cap = q * 20;
        if (cap > 65535) begin
            cap = 65535;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_beat('0, i == n - 1);
            end else begin
                add_beat(rrs_pkg::BURST_W'($urandom_range(0, cap)), i == n - 1);
            end
        end
        added = n;
    endtask

    initial begin
        int                          planned;
        int                          phase;
        int                          sets;
        int                          n;
        int                          added;
        logic [rrs_pkg::QUANT_W-1:0] q;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // quantum at its reset value
        add_beat(16'd0, 1'b1);
        add_beat(16'd3, 1'b0);
        add_beat(16'd0, 1'b0);
        add_beat(16'd5, 1'b0);
        add_beat(16'd1, 1'b1);

        set_quantum(16'hFFFF);
        add_beat(16'hFFFF, 1'b0);
        add_beat(16'd0, 1'b0);
        add_beat(16'hFFFE, 1'b1);

        set_quantum(16'd1);
        add_beat(16'd1, 1'b0);
        add_beat(16'd2, 1'b0);
        add_beat(16'd0, 1'b1);

        // zero quantum behaves as one
        set_quantum(16'd0);
        add_beat(16'd2, 1'b0);
        add_beat(16'd1, 1'b1);

        // overfull set: extra loads dropped, closing beat still schedules
        set_quantum(16'd5);
        for (int i = 0; i < rrs_pkg::MAX_PROCS; i++) begin
            add_beat(rrs_pkg::BURST_W'($urandom_range(0, 60)), 1'b0);
        end
        add_beat(16'hA5A5, 1'b0);
        add_beat(16'h5A5A, 1'b1);
        planned = 13 + rrs_pkg::MAX_PROCS + 2;

        phase = 0;
        while (planned < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: q = 16'd1;
                1: q = 16'd2;
                2: q = rrs_pkg::QUANT_W'($urandom_range(1, 16));
                3: q = 16'hFFFF;
                4: q = rrs_pkg::QUANT_W'($urandom_range(4096, 65535));
                default: q = rrs_pkg::QUANT_W'($urandom_range(1, 65535));
            endcase
            set_quantum(q);
            sets = (phase == 2) ? 3 : $urandom_range(1, 3);
            if (phase == 2) begin
                holds_asked++;
            end
            for (int s = 0; s < sets; s++) begin
                n = ($urandom_range(0, 7) == 0)
                    ? $urandom_range(rrs_pkg::MAX_PROCS + 1, rrs_pkg::MAX_PROCS + 3)
                    : $urandom_range(1, rrs_pkg::MAX_PROCS);
                add_random_set(q, n, added);
                planned += added;
            end
            phase++;
        end

        wait_idle();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
